FILE: rtl/core/skset_pkg.sv
// ----------------------------------------------------------------------------
// skset_pkg: shared definitions for the sorted key set
// Table geometry, key packing widths, opcode and status codes, and the link
// word passed between neighbouring cells of the sorted chain.
// ----------------------------------------------------------------------------
package skset_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int KEY_CHARS     = 8;
    localparam int CHAR_W        = 8;
    localparam int KEY_W         = 64;
    localparam int IDX_W         = $clog2(KEY_CHARS + 1);

    // hit reduction: one registered OR per group, then one OR over groups
    localparam int GROUP_SIZE    = 16;
    localparam int GROUP_COUNT   = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_CHECK    = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
        logic             ge;     // empty, or stored key not below search key
    } skset_link_t;

endpackage

FILE: rtl/core/skset_key_gather.sv
// ----------------------------------------------------------------------------
// skset_key_gather: key assembly
// Folds letters to lower case, packs up to KEY_CHARS characters first char in
// the top byte, stops on a zero character and clears after the last word.
// ----------------------------------------------------------------------------
module skset_key_gather
    import skset_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [CHAR_W-1:0] key_char,
    input  logic              key_last,
    output logic [KEY_W-1:0]  final_key
);

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    logic [KEY_W-1:0] buffer_reg, buffer_next, buffer_upd;
    logic [IDX_W-1:0] index_reg, index_next, index_upd;
    logic             ended_reg, ended_next, ended_upd;
    logic [CHAR_W-1:0] char_fold;
    logic [2:0]        byte_sel;

    always_comb
    begin
        char_fold = key_char;
        if (key_char >= CHAR_UPPER_A && key_char <= CHAR_UPPER_Z)
        begin
            char_fold = key_char + CASE_OFFSET;
        end
        byte_sel   = 3'd7 - 3'(index_reg);
        buffer_upd = buffer_reg;
        index_upd  = index_reg;
        ended_upd  = ended_reg;
        if (!ended_reg && index_reg < IDX_W'(KEY_CHARS))
        begin
            if (key_char == '0)
            begin
                ended_upd = 1'b1;
            end
            else
            begin
                buffer_upd[{byte_sel, 3'b000} +: CHAR_W] = char_fold;
                index_upd = index_reg + 1'b1;
            end
        end
    end

    assign final_key = buffer_upd;

    always_comb
    begin
        buffer_next = buffer_reg;
        index_next  = index_reg;
        ended_next  = ended_reg;
        if (take)
        begin
            if (key_last)
            begin
                buffer_next = '0;
                index_next  = '0;
                ended_next  = 1'b0;
            end
            else
            begin
                buffer_next = buffer_upd;
                index_next  = index_upd;
                ended_next  = ended_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_reg <= '0;
            index_reg  <= '0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            buffer_reg <= buffer_next;
            index_reg  <= index_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

FILE: rtl/core/skset_cell.sv
// ----------------------------------------------------------------------------
// skset_cell: one entry of the sorted chain
// Holds one key, compares it with the broadcast search key and, on insert,
// takes the key of its lower neighbour or the new key.
// ----------------------------------------------------------------------------
module skset_cell
    import skset_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [KEY_W-1:0] search_key,
    input  skset_link_t      prev_link,
    output skset_link_t      link,
    output logic             eq
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic             valid_reg, valid_next;
    logic             ge;

    assign ge   = !valid_reg || (key_reg >= search_key);
    assign eq   = valid_reg && (key_reg == search_key);
    assign link = '{key: key_reg, valid: valid_reg, ge: ge};

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (shift_en && ge)
        begin
            // boundary cell takes the new key, cells above move up one place
            if (prev_link.ge)
            begin
                key_next   = prev_link.key;
                valid_next = prev_link.valid;
            end
            else
            begin
                key_next   = search_key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: rtl/core/sorted_key_set_insert_lookup.sv
// ----------------------------------------------------------------------------
// sorted_key_set_insert_lookup: sorted case-insensitive key set
// Add / check of short text keys held in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Keys arrive one character per input word; letters are folded to lower
// case, only the first KEY_CHARS characters count and a zero character ends
// the key early. Non-final words give no result. The word with key_last set
// goes through these steps: the finished key is latched, then every cell
// compares its entry with the key and the matches are ORed per group of
// GROUP_SIZE cells into a register, and then the groups are ORed, the
// result is decided and, for an add of a new key into a table that is not
// full, the chain shifts by one place above the insert point. The decide
// step waits while an earlier result word is still stalled at the output.
// The table is a chain of TABLE_ENTRIES cells with a valid bit each; reset
// empties it at once, with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_set_insert_lookup
    import skset_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [CHAR_W-1:0] key_char,
    input  logic              key_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic              status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DEC
    } state_t;

    state_t state_reg, state_next;

    logic                    in_take;
    logic [KEY_W-1:0]        final_key;
    logic [KEY_W-1:0]        search_key_reg, search_key_next;
    logic                    opcode_reg, opcode_next;
    logic [GROUP_COUNT-1:0]  grp_hit_reg, grp_hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic                    status_reg, status_next;

    logic                    out_free;
    logic                    hit;
    logic                    full;
    logic                    do_insert;
    logic                    shift_en;

    skset_link_t             link_vec [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] eq_vec;
    logic [TABLE_ENTRIES-1:0] valid_vec;

    // ------------------------------------------------------------------
    // Handshake: take characters only while idle
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    skset_key_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .key_char  (key_char),
        .key_last  (key_last),
        .final_key (final_key)
    );

    // ------------------------------------------------------------------
    // Sorted chain: cell 0 holds the smallest key, empty cells sit on top
    // ------------------------------------------------------------------
    localparam skset_link_t HEAD_LINK = '{key: '0, valid: 1'b1, ge: 1'b0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        skset_link_t prev_link;
        if (i == 0)
        begin : g_head
            assign prev_link = HEAD_LINK;
        end
        else
        begin : g_body
            assign prev_link = link_vec[i-1];
        end

        skset_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .search_key (search_key_reg),
            .prev_link  (prev_link),
            .link       (link_vec[i]),
            .eq         (eq_vec[i])
        );

        assign valid_vec[i] = link_vec[i].valid;
    end

    // Group OR of the per-cell matches, registered in the compare cycle
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            grp_hit_next[g] = 1'b0;
            for (int m = 0; m < GROUP_SIZE; m++)
            begin
                if (g * GROUP_SIZE + m < TABLE_ENTRIES)
                begin
                    grp_hit_next[g] = grp_hit_next[g] | eq_vec[g * GROUP_SIZE + m];
                end
            end
        end
    end

    // Keys are unique, so any match is the entry at the insert point
    assign hit       = |grp_hit_reg;
    assign full      = valid_vec[TABLE_ENTRIES-1];
    assign do_insert = (opcode_reg == OP_ADD) && !hit && !full;
    assign shift_en  = (state_reg == ST_DEC) && out_free && do_insert;

    // ------------------------------------------------------------------
    // Control: gather, compare, decide
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        search_key_next = search_key_reg;
        opcode_next     = opcode_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        status_next     = status_reg;

        // drop the result word once the sink has taken it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && key_last)
                begin
                    search_key_next = final_key;
                    opcode_next     = opcode;
                    state_next      = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit;
                    status_next    = (opcode_reg == OP_ADD && !hit && full) ?
                                     STATUS_FULL : STATUS_OK;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        search_key_reg <= search_key_next;
        opcode_reg     <= opcode_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        if (state_reg == ST_CMP)
        begin
            grp_hit_reg <= grp_hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // occupied cells form an unbroken run from cell 0
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + TABLE_ENTRIES'(1)) & valid_vec) == '0)
        else $error("occupied cells not contiguous");

    // an insert grows the table by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insert did not add exactly one entry");

    // a result word appears only out of the decide cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DEC))
        else $error("result word without a decision");

    // compare always hands over to decide
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (state_reg == ST_DEC))
        else $error("compare cycle not followed by decide");

    // full status only when the last cell is occupied and nothing matched
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC && out_free && status_next == STATUS_FULL) |->
        (full && !hit))
        else $error("full status with room or with a match");

endmodule
